// ----- design/gslm_pkg.sv -----
// shared types and codes for the graph slot list manager
`default_nettype none
package gslm_pkg;

  localparam int CMD_W    = 2;
  localparam int VID_W    = 8;
  localparam int EID_W    = 10;
  localparam int NEWID_W  = 10;
  localparam int VRANGE_W = 9;
  localparam int ERANGE_W = 11;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_NEW_VERTEX = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NEW_EDGE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_VERTEX = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_EDGE   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VID_W-1:0] vertex_id;
    logic [EID_W-1:0] edge_id;
    logic [VID_W-1:0] from_vertex;
    logic [VID_W-1:0] to_vertex;
    logic             edge_one_way;
  } in_item_t;

  typedef struct packed {
    logic [NEWID_W-1:0]  new_id;
    logic [VRANGE_W-1:0] vertex_range;
    logic [ERANGE_W-1:0] edge_range;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef enum logic [12:0] {
    S_INIT        = 13'b0000000000001,
    S_IDLE        = 13'b0000000000010,
    S_START       = 13'b0000000000100,
    S_VNEW_RD     = 13'b0000000001000,
    S_ENEW_RD     = 13'b0000000010000,
    S_ENEW_REV    = 13'b0000000100000,
    S_ENEW_REV_WR = 13'b0000001000000,
    S_EDEL_ENDS   = 13'b0000010000000,
    S_ADJ_RD      = 13'b0000100000000,
    S_WALK        = 13'b0001000000000,
    S_UNLINK      = 13'b0010000000000,
    S_FREE        = 13'b0100000000000,
    S_DONE        = 13'b1000000000000
  } state_t;

endpackage
`default_nettype wire

// ----- design/graph_slot_list_manager_core.sv -----
// top level of the graph slot list manager: command sequencer over the list memories
//
// Keeps a graph as array-linked lists in four synchronous memories: vertex
// next links (free list and live list), adjacency heads per vertex, half-edge
// next links (adjacency lists and edge free list) and edge endpoints. One
// command is taken at a time; a result is held in an output register so the
// next command can be transferred while it waits. Deletes walk the list in
// memory one entry per cycle through the next-link read port, and an
// undirected edge delete then walks the target's list too. A result still
// waiting in the output register holds the sequencer until it is taken.
// After reset and after each write of cfg_wr_data a clearing pass rebuilds
// every chain, one entry a cycle, over max(2*EDGE_CAPACITY, VERTEX_CAPACITY)
// entries (2048 at the defaults); no command is accepted during it.
`default_nettype none
module graph_slot_list_manager_core #(
  parameter int VERTEX_CAPACITY = 256,
  parameter int EDGE_CAPACITY   = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire gslm_pkg::in_item_t   in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      gslm_pkg::out_item_t  out_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data
);

  // widths: pointers carry one extra bit so an all-ones value means empty
  localparam int VAW   = $clog2(VERTEX_CAPACITY);
  localparam int VPW   = VAW + 1;
  localparam int SLOTS = 2 * EDGE_CAPACITY;
  localparam int SAW   = $clog2(SLOTS);
  localparam int SPW   = SAW + 1;
  localparam int EAW   = $clog2(EDGE_CAPACITY);
  localparam int EHW   = EAW + 1;
  localparam int PW    = (VPW > SPW) ? VPW : SPW;
  localparam int SWEEP = (SLOTS > VERTEX_CAPACITY) ? SLOTS : VERTEX_CAPACITY;
  localparam int SWW   = $clog2(SWEEP) + 1;
  localparam int ENDW  = 2 * gslm_pkg::VID_W;

  localparam logic [VPW-1:0] V_NIL = {VPW{1'b1}};
  localparam logic [SPW-1:0] S_NIL = {SPW{1'b1}};

  // state
  gslm_pkg::state_t state_r, state_nxt;
  logic [SWW-1:0]   sw_r, sw_nxt;
  logic             directed_r, directed_nxt;
  logic [VPW-1:0]   vfree_r, vfree_nxt;
  logic [VPW-1:0]   vlive_r, vlive_nxt;
  logic [VPW-1:0]   vhm_r, vhm_nxt;
  logic [SPW-1:0]   efree_r, efree_nxt;
  logic [EHW-1:0]   ehm_r, ehm_nxt;
  logic             out_valid_r, out_valid_nxt;

  // per-command working registers
  gslm_pkg::in_item_t  in_r, in_nxt;
  gslm_pkg::out_item_t out_r, out_nxt;
  logic [SAW-1:0]      d_r, d_nxt;
  logic [EAW-1:0]      e_r, e_nxt;
  logic [gslm_pkg::VID_W-1:0] t_r, t_nxt;
  logic [PW-1:0]       target_r, target_nxt;
  logic [PW:0]         n_r, n_nxt;
  logic                list_adj_r, list_adj_nxt;
  logic [VAW-1:0]      a_r, a_nxt;
  logic                prev_head_r, prev_head_nxt;
  logic [PW-1:0]       prev_r, prev_nxt;
  logic                first_r, first_nxt;
  logic [PW+1:0]       steps_r, steps_nxt;
  logic [PW-1:0]       head_val_r, head_val_nxt;
  logic                second_r, second_nxt;
  logic [gslm_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [gslm_pkg::NEWID_W-1:0]  new_id_r, new_id_nxt;

  // memory ports
  logic             vn_we, vn_re;
  logic [VAW-1:0]   vn_wa, vn_ra;
  logic [VPW-1:0]   vn_wd, vn_rd;
  logic             adj_we, adj_re;
  logic [VAW-1:0]   adj_wa, adj_ra;
  logic [SPW-1:0]   adj_wd, adj_rd;
  logic             hen_we, hen_re;
  logic [SAW-1:0]   hen_wa, hen_ra;
  logic [SPW-1:0]   hen_wd, hen_rd;
  logic             end_we, end_re;
  logic [EAW-1:0]   end_wa, end_ra;
  logic [ENDW-1:0]  end_wd, end_rd;

  gslm_ram #(.DEPTH(VERTEX_CAPACITY), .WIDTH(VPW)) u_vertex_next (
    .clk(clk), .we(vn_we), .waddr(vn_wa), .wdata(vn_wd),
    .re(vn_re), .raddr(vn_ra), .rdata(vn_rd)
  );
  gslm_ram #(.DEPTH(VERTEX_CAPACITY), .WIDTH(SPW)) u_adj_head (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
    .re(adj_re), .raddr(adj_ra), .rdata(adj_rd)
  );
  gslm_ram #(.DEPTH(SLOTS), .WIDTH(SPW)) u_half_edge_next (
    .clk(clk), .we(hen_we), .waddr(hen_wa), .wdata(hen_wd),
    .re(hen_re), .raddr(hen_ra), .rdata(hen_rd)
  );
  gslm_ram #(.DEPTH(EDGE_CAPACITY), .WIDTH(ENDW)) u_edge_ends (
    .clk(clk), .we(end_we), .waddr(end_wa), .wdata(end_wd),
    .re(end_re), .raddr(end_ra), .rdata(end_rd)
  );

  // helper values
  logic [31:0]   sw32;
  logic [PW:0]   slots_n;
  logic [PW-1:0] walk_rd;
  logic [PW-1:0] cur;
  logic          found;
  logic          not_found;
  logic [SAW-1:0] d_new;
  logic [EAW-1:0] e_new;
  logic [SAW-1:0] d_del;
  logic [gslm_pkg::VID_W-1:0] end_from;
  logic [gslm_pkg::VID_W-1:0] end_to;

  assign sw32     = 32'(sw_r);
  assign slots_n  = directed_r ? (PW+1)'(EDGE_CAPACITY) : (PW+1)'(SLOTS);
  assign walk_rd  = list_adj_r ? PW'(hen_rd) : PW'(vn_rd);
  assign cur      = first_r ? head_val_r : walk_rd;
  // a match only counts while the step bound still holds
  assign found     = (cur == target_r) && ((PW+2)'(n_r) >= steps_r);
  assign not_found = !found && (((PW+1)'(cur) >= n_r) || (steps_r > (PW+2)'(n_r)));
  assign d_new    = SAW'(efree_r);
  assign e_new    = directed_r ? EAW'(d_new) : EAW'(d_new >> 1);
  assign d_del    = directed_r ? SAW'(in_r.edge_id) : SAW'({in_r.edge_id, 1'b0});
  assign end_from = end_rd[ENDW-1:gslm_pkg::VID_W];
  assign end_to   = end_rd[gslm_pkg::VID_W-1:0];

  assign in_ready  = (state_r == gslm_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    sw_nxt        = sw_r;
    directed_nxt  = directed_r;
    vfree_nxt     = vfree_r;
    vlive_nxt     = vlive_r;
    vhm_nxt       = vhm_r;
    efree_nxt     = efree_r;
    ehm_nxt       = ehm_r;
    out_valid_nxt = out_valid_r;
    in_nxt        = in_r;
    out_nxt       = out_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    t_nxt         = t_r;
    target_nxt    = target_r;
    n_nxt         = n_r;
    list_adj_nxt  = list_adj_r;
    a_nxt         = a_r;
    prev_head_nxt = prev_head_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    steps_nxt     = steps_r;
    head_val_nxt  = head_val_r;
    second_nxt    = second_r;
    status_nxt    = status_r;
    new_id_nxt    = new_id_r;
    vn_we = 1'b0; vn_wa = '0; vn_wd = '0; vn_re = 1'b0; vn_ra = '0;
    adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_re = 1'b0; adj_ra = '0;
    hen_we = 1'b0; hen_wa = '0; hen_wd = '0; hen_re = 1'b0; hen_ra = '0;
    end_we = 1'b0; end_wa = '0; end_wd = '0; end_re = 1'b0; end_ra = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      gslm_pkg::S_INIT: begin
        // rebuild one entry of every chain per cycle
        vn_we  = (sw32 < VERTEX_CAPACITY);
        vn_wa  = VAW'(sw_r);
        vn_wd  = (sw32 + 1 < VERTEX_CAPACITY) ? VPW'(sw32 + 1) : V_NIL;
        adj_we = (sw32 < VERTEX_CAPACITY);
        adj_wa = VAW'(sw_r);
        adj_wd = S_NIL;
        hen_we = (sw32 < SLOTS);
        hen_wa = SAW'(sw_r);
        if (directed_r) begin
          hen_wd = (sw32 + 1 < EDGE_CAPACITY) ? SPW'(sw32 + 1) : S_NIL;
        end else begin
          hen_wd = (!sw_r[0] && (sw32 + 2 < SLOTS)) ? SPW'(sw32 + 2) : S_NIL;
        end
        sw_nxt = sw_r + 1'b1;
        if (sw_r == SWW'(SWEEP - 1)) begin
          state_nxt = gslm_pkg::S_IDLE;
        end
      end

      gslm_pkg::S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = gslm_pkg::S_START;
        end
      end

      gslm_pkg::S_START: begin
        new_id_nxt    = '0;
        status_nxt    = gslm_pkg::STATUS_OK;
        steps_nxt     = '0;
        first_nxt     = 1'b1;
        prev_head_nxt = 1'b1;
        second_nxt    = 1'b0;
        case (in_r.cmd)
          gslm_pkg::CMD_NEW_VERTEX: begin
            if (32'(vfree_r) >= VERTEX_CAPACITY) begin
              status_nxt = gslm_pkg::STATUS_NO_FREE;
              state_nxt  = gslm_pkg::S_DONE;
            end else begin
              vn_re     = 1'b1;
              vn_ra     = VAW'(vfree_r);
              state_nxt = gslm_pkg::S_VNEW_RD;
            end
          end
          gslm_pkg::CMD_NEW_EDGE: begin
            if ((PW+1)'(efree_r) >= slots_n) begin
              status_nxt = gslm_pkg::STATUS_NO_FREE;
              state_nxt  = gslm_pkg::S_DONE;
            end else if ((32'(in_r.from_vertex) >= VERTEX_CAPACITY) ||
                         (32'(in_r.to_vertex) >= VERTEX_CAPACITY)) begin
              status_nxt = gslm_pkg::STATUS_NOT_FOUND;
              state_nxt  = gslm_pkg::S_DONE;
            end else begin
              d_nxt     = d_new;
              e_nxt     = e_new;
              hen_re    = 1'b1;
              hen_ra    = d_new;
              adj_re    = 1'b1;
              adj_ra    = VAW'(in_r.from_vertex);
              state_nxt = gslm_pkg::S_ENEW_RD;
            end
          end
          gslm_pkg::CMD_DEL_VERTEX: begin
            if (32'(in_r.vertex_id) >= VERTEX_CAPACITY) begin
              status_nxt = gslm_pkg::STATUS_NOT_FOUND;
              state_nxt  = gslm_pkg::S_DONE;
            end else begin
              head_val_nxt = PW'(vlive_r);
              list_adj_nxt = 1'b0;
              n_nxt        = (PW+1)'(VERTEX_CAPACITY);
              target_nxt   = PW'(in_r.vertex_id);
              state_nxt    = gslm_pkg::S_WALK;
            end
          end
          default: begin
            // delete edge
            if (32'(in_r.edge_id) >= EDGE_CAPACITY) begin
              status_nxt = gslm_pkg::STATUS_NOT_FOUND;
              state_nxt  = gslm_pkg::S_DONE;
            end else begin
              d_nxt     = d_del;
              e_nxt     = EAW'(in_r.edge_id);
              end_re    = 1'b1;
              end_ra    = EAW'(in_r.edge_id);
              state_nxt = gslm_pkg::S_EDEL_ENDS;
            end
          end
        endcase
      end

      gslm_pkg::S_VNEW_RD: begin
        // pop free head, push it on the live list
        vfree_nxt = vn_rd;
        vn_we     = 1'b1;
        vn_wa     = VAW'(vfree_r);
        vn_wd     = vlive_r;
        vlive_nxt = vfree_r;
        if (vfree_r == vhm_r) begin
          vhm_nxt = vhm_r + 1'b1;
        end
        new_id_nxt = gslm_pkg::NEWID_W'(vfree_r);
        state_nxt  = gslm_pkg::S_DONE;
      end

      gslm_pkg::S_ENEW_RD: begin
        efree_nxt = hen_rd;
        hen_we    = 1'b1;
        hen_wa    = d_r;
        hen_wd    = adj_rd;
        adj_we    = 1'b1;
        adj_wa    = VAW'(in_r.from_vertex);
        adj_wd    = SPW'(d_r);
        end_we    = 1'b1;
        end_wa    = e_r;
        end_wd    = {in_r.from_vertex, in_r.to_vertex};
        if (EHW'(e_r) == ehm_r) begin
          ehm_nxt = ehm_r + 1'b1;
        end
        new_id_nxt = gslm_pkg::NEWID_W'(e_r);
        if (!directed_r && !in_r.edge_one_way) begin
          state_nxt = gslm_pkg::S_ENEW_REV;
        end else begin
          state_nxt = gslm_pkg::S_DONE;
        end
      end

      gslm_pkg::S_ENEW_REV: begin
        // read target head after the source write has landed
        adj_re    = 1'b1;
        adj_ra    = VAW'(in_r.to_vertex);
        state_nxt = gslm_pkg::S_ENEW_REV_WR;
      end

      gslm_pkg::S_ENEW_REV_WR: begin
        hen_we    = 1'b1;
        hen_wa    = d_r ^ SAW'(1);
        hen_wd    = adj_rd;
        adj_we    = 1'b1;
        adj_wa    = VAW'(in_r.to_vertex);
        adj_wd    = SPW'(d_r ^ SAW'(1));
        state_nxt = gslm_pkg::S_DONE;
      end

      gslm_pkg::S_EDEL_ENDS: begin
        t_nxt = end_to;
        if (32'(end_from) >= VERTEX_CAPACITY) begin
          status_nxt = gslm_pkg::STATUS_NOT_FOUND;
          state_nxt  = gslm_pkg::S_DONE;
        end else begin
          adj_re       = 1'b1;
          adj_ra       = VAW'(end_from);
          a_nxt        = VAW'(end_from);
          target_nxt   = PW'(d_r);
          list_adj_nxt = 1'b1;
          n_nxt        = slots_n;
          state_nxt    = gslm_pkg::S_ADJ_RD;
        end
      end

      gslm_pkg::S_ADJ_RD: begin
        head_val_nxt  = PW'(adj_rd);
        first_nxt     = 1'b1;
        prev_head_nxt = 1'b1;
        steps_nxt     = '0;
        state_nxt     = gslm_pkg::S_WALK;
      end

      gslm_pkg::S_WALK: begin
        // one list entry per cycle; the next link read is issued each step
        if (found || !not_found) begin
          vn_re  = !list_adj_r;
          vn_ra  = VAW'(cur);
          hen_re = list_adj_r;
          hen_ra = SAW'(cur);
        end
        if (found) begin
          state_nxt = gslm_pkg::S_UNLINK;
        end else if (not_found) begin
          if (!second_r) begin
            status_nxt = gslm_pkg::STATUS_NOT_FOUND;
          end
          state_nxt = gslm_pkg::S_DONE;
        end else begin
          prev_nxt      = cur;
          prev_head_nxt = 1'b0;
          first_nxt     = 1'b0;
          steps_nxt     = steps_r + 1'b1;
        end
      end

      gslm_pkg::S_UNLINK: begin
        if (prev_head_r) begin
          if (list_adj_r) begin
            adj_we = 1'b1;
            adj_wa = a_r;
            adj_wd = SPW'(walk_rd);
          end else begin
            vlive_nxt = VPW'(walk_rd);
          end
        end else begin
          vn_we  = !list_adj_r;
          vn_wa  = VAW'(prev_r);
          vn_wd  = VPW'(walk_rd);
          hen_we = list_adj_r;
          hen_wa = SAW'(prev_r);
          hen_wd = SPW'(walk_rd);
        end
        state_nxt = second_r ? gslm_pkg::S_DONE : gslm_pkg::S_FREE;
      end

      gslm_pkg::S_FREE: begin
        if (!list_adj_r) begin
          vn_we     = 1'b1;
          vn_wa     = VAW'(in_r.vertex_id);
          vn_wd     = vfree_r;
          vfree_nxt = VPW'(in_r.vertex_id);
          if (VPW'(in_r.vertex_id) + 1'b1 == vhm_r) begin
            vhm_nxt = VPW'(in_r.vertex_id);
          end
          state_nxt = gslm_pkg::S_DONE;
        end else begin
          hen_we    = 1'b1;
          hen_wa    = d_r;
          hen_wd    = efree_r;
          efree_nxt = SPW'(d_r);
          if (EHW'(e_r) + 1'b1 == ehm_r) begin
            ehm_nxt = EHW'(e_r);
          end
          // undirected: also drop the reverse half from the target's list
          if (!directed_r && (32'(t_r) < VERTEX_CAPACITY)) begin
            adj_re     = 1'b1;
            adj_ra     = VAW'(t_r);
            a_nxt      = VAW'(t_r);
            target_nxt = PW'(d_r ^ SAW'(1));
            second_nxt = 1'b1;
            state_nxt  = gslm_pkg::S_ADJ_RD;
          end else begin
            state_nxt = gslm_pkg::S_DONE;
          end
        end
      end

      gslm_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.new_id       = new_id_r;
          out_nxt.vertex_range = gslm_pkg::VRANGE_W'(vhm_r);
          out_nxt.edge_range   = gslm_pkg::ERANGE_W'(ehm_r);
          out_nxt.status       = status_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = gslm_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = gslm_pkg::S_IDLE;
      end
    endcase

    // mode write restarts the whole store
    if (cfg_wr_en) begin
      directed_nxt = cfg_wr_data;
      state_nxt    = gslm_pkg::S_INIT;
      sw_nxt       = '0;
      vfree_nxt    = '0;
      vlive_nxt    = V_NIL;
      vhm_nxt      = '0;
      efree_nxt    = '0;
      ehm_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gslm_pkg::S_INIT;
      sw_r        <= '0;
      directed_r  <= 1'b1;
      vfree_r     <= '0;
      vlive_r     <= V_NIL;
      vhm_r       <= '0;
      efree_r     <= '0;
      ehm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      directed_r  <= directed_nxt;
      vfree_r     <= vfree_nxt;
      vlive_r     <= vlive_nxt;
      vhm_r       <= vhm_nxt;
      efree_r     <= efree_nxt;
      ehm_r       <= ehm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    out_r       <= out_nxt;
    d_r         <= d_nxt;
    e_r         <= e_nxt;
    t_r         <= t_nxt;
    target_r    <= target_nxt;
    n_r         <= n_nxt;
    list_adj_r  <= list_adj_nxt;
    a_r         <= a_nxt;
    prev_head_r <= prev_head_nxt;
    prev_r      <= prev_nxt;
    first_r     <= first_nxt;
    steps_r     <= steps_nxt;
    head_val_r  <= head_val_nxt;
    second_r    <= second_nxt;
    status_r    <= status_nxt;
    new_id_r    <= new_id_nxt;
  end

`ifndef SYNTHESIS
  // a transfer in always starts a command
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !cfg_wr_en) |=> (state_r == gslm_pkg::S_START))
    else $error("accepted command did not start");

  // a mode write blocks commands while the chains are rebuilt
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_ready)
    else $error("command accepted during clearing pass");

  // the walk never runs past its step bound
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gslm_pkg::S_WALK) |-> (steps_r <= (PW+2)'(n_r) + 1'b1))
    else $error("list walk exceeded its bound");

  // the vertex free head is a slot or empty
  a_vfree_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(vfree_r) < VERTEX_CAPACITY) || (vfree_r == V_NIL))
    else $error("vertex free head corrupt");
`endif

endmodule
`default_nettype wire

// ----- design/gslm_ram.sv -----
// simple dual-port synchronous ram, one write and one registered read
`default_nettype none
module gslm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- tb/gslm_checker.sv -----
// transfer monitor, graph store predictor and result comparison for the list manager
module gslm_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire gslm_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire gslm_pkg::out_item_t out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data,
  output int                       mismatch_count,
  output int                       results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 256;
  localparam int NE = 1024;
  localparam int NS = 2 * NE;
  localparam int unsigned NONE = 32'hFFFF_FFFF;

  bit          directed;
  int unsigned vtx_link[NV];
  int unsigned adj_head[NV];
  int unsigned half_link[NS];
  int unsigned ends_src[NE];
  int unsigned ends_dst[NE];
  int unsigned vtx_free, vtx_live, vtx_top, edge_free, edge_top;
  gslm_pkg::out_item_t expected_results[$];

  function automatic void rebuild_store();
    for (int i = 0; i < NV; i++) begin
      vtx_link[i] = (i + 1 < NV) ? i + 1 : NONE;
      adj_head[i] = NONE;
    end
    for (int i = 0; i < NS; i++) half_link[i] = NONE;
    for (int i = 0; i + 1 < NE; i++) begin
      if (directed) half_link[i] = i + 1;
      else half_link[2 * i] = 2 * i + 2;
    end
    for (int i = 0; i < NE; i++) begin
      ends_src[i] = 0;
      ends_dst[i] = 0;
    end
    vtx_free = 0;
    vtx_live = NONE;
    vtx_top = 0;
    edge_free = 0;
    edge_top = 0;
  endfunction

  // remove a half-edge slot from a vertex's adjacency list, 1 when found
  function automatic bit drop_half_edge(int unsigned owner, int unsigned slot,
                                        int unsigned nslots);
    int unsigned prev, cur, steps;
    prev = NONE;
    cur = adj_head[owner];
    steps = 0;
    while (cur != NONE && steps <= nslots) begin
      if (cur == slot) begin
        if (prev == NONE) adj_head[owner] = half_link[cur];
        else half_link[prev] = half_link[cur];
        return 1;
      end
      if (cur >= nslots) return 0;
      prev = cur;
      cur = half_link[cur];
      steps++;
    end
    return 0;
  endfunction

  function automatic gslm_pkg::out_item_t apply_command(gslm_pkg::in_item_t cmd_in);
    gslm_pkg::out_item_t res;
    int unsigned slots, d, e, prev, cur, steps;
    bit          found;
    slots = directed ? NE : NS;
    res = '0;
    res.status = gslm_pkg::STATUS_OK;
    case (cmd_in.cmd)
      gslm_pkg::CMD_NEW_VERTEX: begin
        d = vtx_free;
        if (d >= NV) begin
          res.status = gslm_pkg::STATUS_NO_FREE;
        end else begin
          vtx_free = vtx_link[d];
          vtx_link[d] = vtx_live;
          vtx_live = d;
          if (d == vtx_top) vtx_top++;
          res.new_id = d[gslm_pkg::NEWID_W-1:0];
        end
      end
      gslm_pkg::CMD_NEW_EDGE: begin
        d = edge_free;
        if (d >= slots) begin
          res.status = gslm_pkg::STATUS_NO_FREE;
        end else begin
          e = directed ? d : d >> 1;
          edge_free = half_link[d];
          half_link[d] = adj_head[cmd_in.from_vertex];
          adj_head[cmd_in.from_vertex] = d;
          if (!directed && !cmd_in.edge_one_way) begin
            half_link[d ^ 1] = adj_head[cmd_in.to_vertex];
            adj_head[cmd_in.to_vertex] = d ^ 1;
          end
          ends_src[e] = 32'(cmd_in.from_vertex);
          ends_dst[e] = 32'(cmd_in.to_vertex);
          if (e == edge_top) edge_top++;
          res.new_id = e[gslm_pkg::NEWID_W-1:0];
        end
      end
      gslm_pkg::CMD_DEL_VERTEX: begin
        found = 0;
        prev = NONE;
        cur = vtx_live;
        steps = 0;
        while (!found && cur != NONE && steps <= NV && cur < NV) begin
          if (cur == 32'(cmd_in.vertex_id)) begin
            found = 1;
          end else begin
            prev = cur;
            cur = vtx_link[cur];
            steps++;
          end
        end
        if (!found) begin
          res.status = gslm_pkg::STATUS_NOT_FOUND;
        end else begin
          if (prev == NONE) vtx_live = vtx_link[cur];
          else vtx_link[prev] = vtx_link[cur];
          vtx_link[cur] = vtx_free;
          vtx_free = cur;
          if (cur + 1 == vtx_top) vtx_top = cur;
        end
      end
      default: begin
        e = 32'(cmd_in.edge_id);
        d = directed ? e : e << 1;
        if (!drop_half_edge(ends_src[e], d, slots)) begin
          res.status = gslm_pkg::STATUS_NOT_FOUND;
        end else begin
          half_link[d] = edge_free;
          edge_free = d;
          // the reverse half may already be gone from the target's list
          if (!directed) void'(drop_half_edge(ends_dst[e], d ^ 1, slots));
          if (e + 1 == edge_top) edge_top = e;
        end
      end
    endcase
    res.vertex_range = vtx_top[gslm_pkg::VRANGE_W-1:0];
    res.edge_range = edge_top[gslm_pkg::ERANGE_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    gslm_pkg::out_item_t want;
    if (!rst_n) begin
      directed = 1;
      rebuild_store();
      expected_results.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        directed = cfg_wr_data;
        rebuild_store();
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result transfer: %p", out_data);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.new_id !== out_data.new_id || want.vertex_range !== out_data.vertex_range
              || want.edge_range !== out_data.edge_range || want.status !== out_data.status)
          begin
            if (mismatch_count < 10)
              $display("result mismatch: expected %p, got %p", want, out_data);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_command(in_data));
    end
    results_owed = expected_results.size();
  end
endmodule

// ----- tb/tb_graph_slot_list_manager_core.sv -----
// testbench top for the graph slot list manager: command stimulus, result sink, verdict
module tb_graph_slot_list_manager_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_ready;
  gslm_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  gslm_pkg::out_item_t out_data;
  logic      cfg_wr_en = 0;
  logic      cfg_wr_data = 0;
  int        mismatch_count;
  int        results_owed;

  // idling knobs, percent of cycles
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  bit        hold_req = 0;
  bit        hold_done = 0;
  int        hold_left = 0;

  // edge ids with written endpoints since the last store rebuild
  bit        edge_written[1024];
  int        edge_ids[$];
  logic [gslm_pkg::CMD_W-1:0] cmds_in_flight[$];
  int        quiet_cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  graph_slot_list_manager_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  gslm_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  // result sink: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 0;
      hold_left <= 400;
      hold_done <= 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // learn which edge ids got endpoints, and watch for a hung block
  always @(posedge clk) begin
    logic [gslm_pkg::CMD_W-1:0] c;
    if (rst_n) begin
      if (in_valid && in_ready) cmds_in_flight.push_back(in_data.cmd);
      if (out_valid && out_ready && cmds_in_flight.size() > 0) begin
        c = cmds_in_flight.pop_front();
        if (c == gslm_pkg::CMD_NEW_EDGE && out_data.status == gslm_pkg::STATUS_OK
            && !edge_written[out_data.new_id]) begin
          edge_written[out_data.new_id] = 1;
          edge_ids.push_back(32'(out_data.new_id));
        end
      end
      // the clearing pass and the longest list walks stay far below this
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 40000) begin
        $display("graph_slot_list_manager_core verification failed");
        $finish;
      end
    end
  end

  // after a transfer the sender idles each cycle with the set probability
  task automatic send_cmd(gslm_pkg::in_item_t item);
    in_valid <= 1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
  endtask

  // idle point: all results back, then a short pause before touching the mode
  task automatic write_mode(bit dir);
    in_valid <= 0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= dir;
    @(posedge clk);
    cfg_wr_en <= 0;
    edge_written = '{default: 0};
    edge_ids.delete();
  endtask

  function automatic gslm_pkg::in_item_t make_cmd(logic [gslm_pkg::CMD_W-1:0] c, int vid,
                                                  int eid, int src, int dst, bit one_way);
    gslm_pkg::in_item_t it;
    it.cmd = c;
    it.vertex_id = gslm_pkg::VID_W'(vid);
    it.edge_id = gslm_pkg::EID_W'(eid);
    it.from_vertex = gslm_pkg::VID_W'(src);
    it.to_vertex = gslm_pkg::VID_W'(dst);
    it.edge_one_way = one_way;
    return it;
  endfunction

  // weights in percent: new vertex, new edge, delete vertex; the rest deletes edges
  task automatic run_random(int n, int w_nv, int w_ne, int w_dv);
    gslm_pkg::in_item_t it;
    int       r;
    for (int k = 0; k < n; k++) begin
      it = $bits(gslm_pkg::in_item_t)'({$urandom, $urandom});
      r = $urandom_range(99);
      if (r < w_nv) begin
        it.cmd = gslm_pkg::CMD_NEW_VERTEX;
      end else if (r < w_nv + w_ne || edge_ids.size() == 0) begin
        it.cmd = gslm_pkg::CMD_NEW_EDGE;
        // a small pool of endpoints keeps adjacency lists long
        if ($urandom_range(3) != 0) begin
          it.from_vertex = gslm_pkg::VID_W'($urandom_range(15));
          it.to_vertex = gslm_pkg::VID_W'($urandom_range(15));
        end
      end else if (r < w_nv + w_ne + w_dv) begin
        it.cmd = gslm_pkg::CMD_DEL_VERTEX;
        if ($urandom_range(3) != 0) it.vertex_id = gslm_pkg::VID_W'($urandom_range(63));
      end else begin
        it.cmd = gslm_pkg::CMD_DEL_EDGE;
        it.edge_id = gslm_pkg::EID_W'(edge_ids[$urandom_range(edge_ids.size() - 1)]);
      end
      send_cmd(it);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed slots after reset: empty lists, extremes, high mark moves
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_VERTEX, 0, 1023, 255, 0, 1));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_VERTEX, 255, 0, 0, 255, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_NEW_VERTEX, 255, 1023, 255, 255, 1));
    send_cmd(make_cmd(gslm_pkg::CMD_NEW_VERTEX, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_NEW_VERTEX, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_NEW_EDGE, 0, 0, 0, 1, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_NEW_EDGE, 0, 0, 255, 255, 1));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_EDGE, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_EDGE, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_EDGE, 0, 1, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_VERTEX, 2, 0, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_VERTEX, 1, 0, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_VERTEX, 5, 0, 0, 0, 0));

    // paired half-edge slots: self loop, one-way, reverse half unlinking
    write_mode(0);
    send_cmd(make_cmd(gslm_pkg::CMD_NEW_VERTEX, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_NEW_EDGE, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_NEW_EDGE, 0, 0, 0, 3, 1));
    send_cmd(make_cmd(gslm_pkg::CMD_NEW_EDGE, 0, 0, 3, 7, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_EDGE, 0, 1, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_EDGE, 0, 2, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_EDGE, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(gslm_pkg::CMD_DEL_EDGE, 0, 0, 0, 0, 0));

    // no idling, with one long receiver hold-off while commands keep coming
    write_mode(1);
    hold_req <= 1;
    run_random(150, 20, 40, 15);

    tx_idle_pct = 51;
    write_mode(0);
    run_random(250, 15, 60, 10);

    // vertex flood runs the free list dry
    tx_idle_pct = 0;
    rx_stall_pct = 51;
    write_mode(1);
    run_random(350, 80, 10, 5);

    tx_idle_pct = 19;
    rx_stall_pct = 19;
    write_mode(1);
    run_random(400, 5, 85, 3);

    in_valid <= 0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("graph_slot_list_manager_core verification clean");
    else
      $display("graph_slot_list_manager_core verification failed");
    $finish;
  end
endmodule
